### rtl/cih_pkg.sv
package cih_pkg;

  // histogram geometry
  localparam int unsigned NUM_BINS    = 256;
  localparam int unsigned BIN_W       = $clog2(NUM_BINS);
  localparam int unsigned CNT_W       = 21;
  localparam int unsigned SUM_W       = CNT_W + 1;

  // count bound, limited to what the count field holds
  localparam int unsigned MAX_PIXELS  = 1048576;
  localparam int unsigned FIELD_MAX   = (1 << CNT_W) - 1;
  localparam int unsigned CAP_VALUE   = (MAX_PIXELS > FIELD_MAX) ? FIELD_MAX : MAX_PIXELS;
  localparam logic [CNT_W-1:0] COUNT_CAP = CAP_VALUE[CNT_W-1:0];

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request codes on the input channel
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // classified operation held in the queue
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } cih_op_e;

  typedef struct packed {
    cih_op_e           op;
    logic [BIN_W-1:0]  index;
  } cih_item_t;

  // queue head as seen by the back part
  typedef struct packed {
    logic       valid;
    cih_item_t  item;
  } cih_head_t;

endpackage

### rtl/cih_ram.sv
module cih_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cih_front.sv
module cih_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        pixel_value_i,
  input  logic [7:0]        bin_index_i,
  output cih_pkg::cih_head_t head_o,
  input  logic              pop_i
);
  import cih_pkg::*;

  cih_item_t         entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              full;
  logic              keep;
  logic              push;
  logic              pop;
  cih_item_t         item;

  // classify the request, unused code is dropped
  always_comb begin
    item.op    = OP_ADD;
    item.index = pixel_value_i;
    keep       = 1'b1;
    case (req_type_i)
      REQ_ADD: begin
        item.op    = OP_ADD;
        item.index = pixel_value_i;
      end
      REQ_READ: begin
        item.op    = OP_READ;
        item.index = bin_index_i;
      end
      REQ_CLEAR: begin
        item.op    = OP_CLEAR;
        item.index = bin_index_i;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full && keep;
  assign pop        = pop_i && (count_q != '0);

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= item;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entries_q[rptr_q];

endmodule

### rtl/cih_back.sv
module cih_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cih_pkg::cih_head_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [20:0]        bin_count_o,
  output logic [20:0]        cumulative_count_o
);
  import cih_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADD  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [BIN_W-1:0]   idx_q, idx_d;
  logic [BIN_W-1:0]   sel_q, sel_d;
  logic [CNT_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [NUM_BINS-1:0] valid_q;
  logic               rd_valid_q;
  logic [BIN_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   rd_data;
  logic [CNT_W-1:0]   rd_cnt;
  logic               we;
  logic [CNT_W-1:0]   wdata;
  logic               clear_all;
  logic [SUM_W-1:0]   sum_add;
  logic               out_load;
  logic               out_valid_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic [CNT_W-1:0]   out_sum_q;

  cih_ram #(
    .WIDTH(CNT_W),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // bins never written since reset or clear read as zero
  assign rd_cnt  = rd_valid_q ? rd_data : '0;
  assign sum_add = {1'b0, sum_q} + {1'b0, rd_cnt};
  assign wdata   = (rd_cnt < COUNT_CAP) ? (rd_cnt + CNT_W'(1)) : COUNT_CAP;

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sel_d     = sel_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    rd_addr   = idx_q;
    we        = 1'b0;
    clear_all = 1'b0;
    pop_o     = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.item.op)
            OP_ADD: begin
              rd_addr = head_i.item.index;
              idx_d   = head_i.item.index;
              state_d = ST_ADD;
            end
            OP_READ: begin
              rd_addr = '0;
              idx_d   = '0;
              sel_d   = head_i.item.index;
              sum_d   = '0;
              state_d = ST_SUM;
            end
            OP_CLEAR: begin
              clear_all = 1'b1;
            end
            default: begin
              clear_all = 1'b0;
            end
          endcase
        end
      end
      ST_ADD: begin
        // saturating increment written back
        we      = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SUM: begin
        // accumulate the bin whose data arrives this cycle
        sum_d = (sum_add > {1'b0, COUNT_CAP}) ? COUNT_CAP : sum_add[CNT_W-1:0];
        cnt_d = rd_cnt;
        if (idx_q == sel_q) begin
          state_d = ST_OUT;
        end else begin
          idx_d   = idx_q + BIN_W'(1);
          rd_addr = idx_q + BIN_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= valid_q[rd_addr];
      if (clear_all) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and output register
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    sel_q <= sel_d;
    sum_q <= sum_d;
    cnt_q <= cnt_d;
    if (out_load) begin
      out_cnt_q <= cnt_q;
      out_sum_q <= sum_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign bin_count_o        = out_cnt_q;
  assign cumulative_count_o = out_sum_q;

  // the cumulative sum always covers the reported bin
  a_sum_covers_bin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_sum_q >= out_cnt_q))
    else $error("cumulative count below bin count");

  // counts never pass the bound
  a_count_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q <= COUNT_CAP))
    else $error("bin count above bound");

  // the walk never runs past the requested bin
  a_walk_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (idx_q <= sel_q))
    else $error("bin walk past requested bin");

  // a write back always follows the read of its bin
  a_add_after_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |-> ($past(state_q) == ST_IDLE))
    else $error("write back without read");

  // no new result is loaded over one still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result overwritten");

endmodule

### rtl/cumulative_intensity_histogram_unit.sv
// Results: add and clear transactions give no result; a read of bin k delivers its
//   result once the walk over the bin memory port has summed bins 0 through k.
// Flow: the back end handles one command at a time, and a read result can be held by out_stall_i;
//   a 4-entry command queue lets the input run ahead of the back end.
// Reset: asynchronous, active low; per-bin valid flags are cleared at once, so all bins
//   read as zero right after reset and after a clear, with no clearing pass.
module cumulative_intensity_histogram_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  pixel_value_i,
  input  logic [7:0]  bin_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] bin_count_o,
  output logic [20:0] cumulative_count_o
);
  import cih_pkg::*;

  cih_head_t head;
  logic      pop;

  // front: accept and classify into the queue
  cih_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .pixel_value_i (pixel_value_i),
    .bin_index_i   (bin_index_i),
    .head_o        (head),
    .pop_i         (pop)
  );

  // back: update bins and walk cumulative sums
  cih_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .bin_count_o        (bin_count_o),
    .cumulative_count_o (cumulative_count_o)
  );

endmodule
